FILE: src/bms_info_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the info frame parser
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BMS_INFO_FRAME_PARSER_DEFINES_SVH
`define BMS_INFO_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bifp_pkg.sv
// ----------------------------------------------------------------------------
// Info frame parser package
// Field codes, frame layout constants and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bifp_pkg;

  localparam int FRAME_LEN = 35;

  localparam logic [7:0]  FRAME_MAGIC = 8'hDD;
  localparam logic [7:0]  INFO_TYPE   = 8'h03;
  localparam logic [7:0]  STATUS_OK   = 8'h00;
  localparam logic [15:0] CSUM_XOR    = 16'hFFFF;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
  localparam logic [15:0] TEMP_OFFSET_RESET = 16'd2731;

  // Request kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Result codes; the first failing check is reported.
  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_TYPE   = 3'd2,
    ERR_STATUS = 3'd3,
    ERR_CSUM   = 3'd4
  } err_t;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT     = 1'b0;
  localparam logic REG_TEMP_OFFSET = 1'b1;

endpackage

`default_nettype wire

FILE: src/bifp_if.sv
// ----------------------------------------------------------------------------
// Info frame parser channels
// Valid/ready channels for the incoming requests and the parsed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bifp_in_if import bifp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface bifp_out_if import bifp_pkg::*; ();
  logic        valid;
  logic        ready;
  err_t        error_code;
  logic [15:0] volts;
  logic signed [15:0] amps;
  logic [15:0] capacity_ah;
  logic [7:0]  capacity_percent;
  logic signed [15:0] temp_one;
  logic signed [15:0] temp_two;
  logic signed [15:0] temp_three;

  modport source (
    output valid, output error_code, output volts, output amps, output capacity_ah,
    output capacity_percent, output temp_one, output temp_two, output temp_three,
    input ready
  );
  modport sink (
    input valid, input error_code, input volts, input amps, input capacity_ah,
    input capacity_percent, input temp_one, input temp_two, input temp_three,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bms_info_frame_parser.sv
// ----------------------------------------------------------------------------
// Battery monitor basic-info frame parser
// Collects one reply frame per request, checks it and reports its fields.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req       in         mode (start / byte / tick), rx_byte
//   rsp       out        error_code and the decoded pack fields
//   cfg_*     in         write-only registers: timeout_ticks, temp_offset
//
// One request per cycle is sustained whenever the request port is ready.
// A request that closes the frame marks a result as pending; the checks run on
// the captured bytes and the result is offered once the output register is free.
// The request port stalls only while a result is pending and the output
// register still holds an earlier result that the consumer has not taken.
// Reset (rst, synchronous) closes any request and empties the output.
//
// Only the frame bytes that the result uses are kept: the header bytes 0 to
// 9, byte 23 and the tail bytes 27 to 34. The checksum is summed as the bytes
// arrive, since the length byte is always received before the summed range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bms_info_frame_parser_defines.svh"

module bms_info_frame_parser import bifp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  bifp_in_if.sink          req,
  bifp_out_if.source       rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef struct packed {
    err_t        error_code;
    logic [15:0] volts;
    logic [15:0] amps;
    logic [15:0] capacity_ah;
    logic [7:0]  capacity_percent;
    logic [15:0] temp_one;
    logic [15:0] temp_two;
    logic [15:0] temp_three;
  } result_t;

  // Configuration registers.
  logic [15:0] timeout_ticks;
  logic [15:0] temp_offset;

  // Request state.
  logic        request_open;
  logic        start_seen;
  logic [5:0]  byte_index;
  logic [16:0] tick_count;
  logic [15:0] sum;

  // Captured frame bytes.
  logic [7:0]  hdr [10];
  logic [7:0]  pct;
  logic [7:0]  tail [8];

  // Result path.
  logic        close_pending;
  logic        out_valid;
  result_t     out_data;

  logic        can_load;
  logic        accept;
  mode_t       mode_in;
  logic        seen_next;
  logic        store;
  logic        close_now;
  logic [16:0] tick_next;
  logic [2:0]  tail_off;
  logic [8:0]  sum_limit;
  result_t     result_next;
  logic [15:0] csum_calc;
  logic [15:0] csum_rx;

  // Data fields of the offered result, all zero after a failed check.
  logic [119:0] rsp_data;

  // The output register may take a new result when it is empty or drained now.
  assign can_load  = !out_valid || rsp.ready;
  assign req.ready = !close_pending || can_load;
  assign accept    = req.valid && req.ready;
  assign mode_in   = mode_t'(req.mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      temp_offset   <= TEMP_OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:     timeout_ticks <= cfg_data;
        REG_TEMP_OFFSET: temp_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte capture decisions. Once the magic byte has been seen every byte is
  // stored, and the frame closes with the byte that fills the last position.
  assign seen_next = start_seen || (req.rx_byte == FRAME_MAGIC);
  assign store     = seen_next && (byte_index < 6'(FRAME_LEN));
  // Tail position of bytes 27 to 34; 27 leaves 3 in the low three bits.
  assign tail_off  = byte_index[2:0] - 3'd3;
  // A byte counts toward the checksum while its position is below 4 + length.
  assign sum_limit = {1'b0, hdr[3]} + 9'd4;
  assign tick_next = (tick_count == '1) ? tick_count : tick_count + 17'd1;

  always_comb begin
    close_now = 1'b0;
    if (request_open) begin
      unique case (mode_in)
        MODE_BYTE: close_now = store && (byte_index == 6'(FRAME_LEN - 1));
        MODE_TICK: close_now = tick_next > {1'b0, timeout_ticks};
        default:   close_now = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_open <= 1'b0;
      start_seen   <= 1'b0;
      byte_index   <= '0;
      tick_count   <= '0;
    end else if (accept) begin
      if (mode_in == MODE_START) begin
        request_open <= 1'b1;
        start_seen   <= 1'b0;
        byte_index   <= '0;
        tick_count   <= '0;
      end else if (request_open) begin
        if (close_now) begin
          request_open <= 1'b0;
        end
        if (mode_in == MODE_BYTE) begin
          start_seen <= seen_next;
          if (store) begin
            byte_index <= byte_index + 6'd1;
          end
        end else if (mode_in == MODE_TICK) begin
          tick_count <= tick_next;
        end
      end
    end
  end

  // Frame bytes and running checksum; cleared by every start request.
  always_ff @(posedge clk) begin
    if (accept && mode_in == MODE_START) begin
      for (int i = 0; i < 10; i++) begin
        hdr[i] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        tail[i] <= '0;
      end
      pct <= '0;
      sum <= '0;
    end else if (accept && request_open && mode_in == MODE_BYTE && store) begin
      if (byte_index < 6'd10) begin
        hdr[byte_index[3:0]] <= req.rx_byte;
      end
      if (byte_index == 6'd23) begin
        pct <= req.rx_byte;
      end
      if (byte_index >= 6'd27) begin
        tail[tail_off] <= req.rx_byte;
      end
      if (byte_index >= 6'd4 && {3'b0, byte_index} < sum_limit) begin
        sum <= sum + {8'h00, req.rx_byte};
      end
    end
  end

  // Frame checks on the captured bytes, in priority order.
  assign csum_calc = (sum + {8'h00, hdr[3]} - 16'd1) ^ CSUM_XOR;
  assign csum_rx   = {tail[6], tail[7]};

  always_comb begin
    result_next = '0;
    priority if (hdr[0] != FRAME_MAGIC) begin
      result_next.error_code = ERR_MAGIC;
    end else if (hdr[1] != INFO_TYPE) begin
      result_next.error_code = ERR_TYPE;
    end else if (hdr[2] != STATUS_OK) begin
      result_next.error_code = ERR_STATUS;
    end else if (csum_calc != csum_rx) begin
      result_next.error_code = ERR_CSUM;
    end else begin
      result_next.error_code       = ERR_OK;
      result_next.volts            = {hdr[4], hdr[5]};
      result_next.amps             = {hdr[6], hdr[7]};
      result_next.capacity_ah      = {hdr[8], hdr[9]};
      result_next.capacity_percent = pct;
      result_next.temp_one         = {tail[0], tail[1]} - temp_offset;
      result_next.temp_two         = {tail[2], tail[3]} - temp_offset;
      result_next.temp_three       = {tail[4], tail[5]} - temp_offset;
    end
  end

  // A pending result is loaded from the captured bytes before a following
  // start request can clear them, since both happen at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      close_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (close_pending && can_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        close_pending <= close_now;
      end else if (can_load) begin
        close_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close_pending && can_load) begin
      out_data <= result_next;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.error_code       = out_data.error_code;
  assign rsp.volts            = out_data.volts;
  assign rsp.amps             = out_data.amps;
  assign rsp.capacity_ah      = out_data.capacity_ah;
  assign rsp.capacity_percent = out_data.capacity_percent;
  assign rsp.temp_one         = out_data.temp_one;
  assign rsp.temp_two         = out_data.temp_two;
  assign rsp.temp_three       = out_data.temp_three;

  assign rsp_data = {rsp.volts, rsp.amps, rsp.capacity_ah, rsp.capacity_percent,
                     rsp.temp_one, rsp.temp_two, rsp.temp_three};

  // A pending result must not be overrun by new requests while output is full.
  `BIFP_ASSERT_NOW(a_stall_when_full, close_pending && !can_load, !req.ready, "result overrun")
  // While a result is pending, the output is valid in the following cycle.
  `BIFP_ASSERT_NEXT(a_pending_shows, close_pending, rsp.valid, "pending result not shown")
  // Failed frames report no data.
  `BIFP_ASSERT_NOW(a_error_zero, rsp.valid && rsp.error_code != ERR_OK, rsp_data == '0, "data on error")

endmodule

`default_nettype wire

FILE: test/bifp_checker.sv
// ----------------------------------------------------------------------------
// Info frame parser result checker
// Watches the request, result and register ports, rebuilds each frame as the
// parser should see it, and compares every decoded result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bifp_checker import bifp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  bifp_in_if               req,
  bifp_out_if              rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               frames_closed,
  output int               frames_ok
);

  typedef struct packed {
    err_t               error_code;
    logic [15:0]        volts;
    logic signed [15:0] amps;
    logic [15:0]        capacity_ah;
    logic [7:0]         capacity_percent;
    logic signed [15:0] temp_one;
    logic signed [15:0] temp_two;
    logic signed [15:0] temp_three;
  } pack_info_t;

  logic [7:0]  captured [FRAME_LEN];
  int          fill;
  bit          synced;
  bit          frame_open;
  logic [16:0] elapsed;
  logic [15:0] timeout_cfg;
  logic [15:0] offset_cfg;
  pack_info_t  expected_info [$];
  int          mismatches = 0;
  int          closed = 0;
  int          clean = 0;

  function automatic pack_info_t decode_frame();
    pack_info_t  r;
    logic [15:0] sum;
    int          len;
    int          p;
    r   = '0;
    len = captured[3];
    if (captured[0] != FRAME_MAGIC) begin
      r.error_code = ERR_MAGIC;
    end else if (captured[1] != INFO_TYPE) begin
      r.error_code = ERR_TYPE;
    end else if (captured[2] != STATUS_OK) begin
      r.error_code = ERR_STATUS;
    end else begin
      // The summed range is clipped at the end of the frame.
      sum = '0;
      for (p = 4; p < 4 + len && p < FRAME_LEN; p++) sum = sum + 16'(captured[p]);
      sum = (sum + 16'(len) - 16'd1) ^ CSUM_XOR;
      if (sum != {captured[33], captured[34]}) r.error_code = ERR_CSUM;
    end
    if (r.error_code == ERR_OK) begin
      r.volts            = {captured[4], captured[5]};
      r.amps             = {captured[6], captured[7]};
      r.capacity_ah      = {captured[8], captured[9]};
      r.capacity_percent = captured[23];
      r.temp_one         = {captured[27], captured[28]} - offset_cfg;
      r.temp_two         = {captured[29], captured[30]} - offset_cfg;
      r.temp_three       = {captured[31], captured[32]} - offset_cfg;
    end
    return r;
  endfunction

  function automatic void close_frame();
    frame_open = 1'b0;
    expected_info.push_back(decode_frame());
  endfunction

  function automatic void apply_request(input logic [1:0] m, input logic [7:0] b);
    case (m)
      MODE_START: begin
        foreach (captured[i]) captured[i] = 8'h00;
        fill       = 0;
        synced     = 1'b0;
        elapsed    = '0;
        frame_open = 1'b1;
      end
      MODE_BYTE: begin
        if (frame_open) begin
          if (b == FRAME_MAGIC) synced = 1'b1;
          if (synced && fill < FRAME_LEN) begin
            captured[fill] = b;
            fill++;
          end
          if (fill >= FRAME_LEN) close_frame();
        end
      end
      MODE_TICK: begin
        if (frame_open) begin
          if (elapsed != 17'h1FFFF) elapsed = elapsed + 17'd1;
          if (elapsed > {1'b0, timeout_cfg}) close_frame();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag(input string field, input int want, input int got);
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
    mismatches++;
  endfunction

  function automatic void check_result();
    pack_info_t want;
    pack_info_t got;
    got.error_code       = rsp.error_code;
    got.volts            = rsp.volts;
    got.amps             = rsp.amps;
    got.capacity_ah      = rsp.capacity_ah;
    got.capacity_percent = rsp.capacity_percent;
    got.temp_one         = rsp.temp_one;
    got.temp_two         = rsp.temp_two;
    got.temp_three       = rsp.temp_three;
    if (expected_info.size() == 0) begin
      $error("result with no closed frame behind it: error_code %0d", got.error_code);
      mismatches++;
    end else begin
      want = expected_info.pop_front();
      closed++;
      if (want.error_code == ERR_OK) clean++;
      if (got.error_code !== want.error_code)
        flag("error_code", int'(want.error_code), int'(got.error_code));
      if (got.volts !== want.volts) flag("volts", want.volts, got.volts);
      if (got.amps !== want.amps) flag("amps", want.amps, got.amps);
      if (got.capacity_ah !== want.capacity_ah)
        flag("capacity_ah", want.capacity_ah, got.capacity_ah);
      if (got.capacity_percent !== want.capacity_percent)
        flag("capacity_percent", want.capacity_percent, got.capacity_percent);
      if (got.temp_one !== want.temp_one) flag("temp_one", want.temp_one, got.temp_one);
      if (got.temp_two !== want.temp_two) flag("temp_two", want.temp_two, got.temp_two);
      if (got.temp_three !== want.temp_three)
        flag("temp_three", want.temp_three, got.temp_three);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (captured[i]) captured[i] = 8'h00;
      fill        = 0;
      synced      = 1'b0;
      frame_open  = 1'b0;
      elapsed     = '0;
      timeout_cfg = TIMEOUT_RESET;
      offset_cfg  = TEMP_OFFSET_RESET;
      expected_info.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready) apply_request(req.mode, req.rx_byte);
      if (cfg_we) begin
        if (cfg_index == REG_TIMEOUT) timeout_cfg = cfg_data;
        else offset_cfg = cfg_data;
      end
    end
    pending       <= expected_info.size();
    fail_count    <= mismatches;
    frames_closed <= closed;
    frames_ok     <= clean;
  end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Info frame parser testbench
// Drives start, byte and tick requests into the parser with random gaps and
// result back-pressure, steps the register settings between phases, and
// leaves the prediction and comparison to the checker beside the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bifp_pkg::*;

  // The mode field has one code the parser does not define; it must be ignored.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int ITEM_TARGET   = 1450;
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is a drain plus register writes.
  localparam int STALL_LIMIT   = 2000;
  // Quiet cycles after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    FAULT_NONE,
    FAULT_TYPE,
    FAULT_STATUS,
    FAULT_CSUM
  } fault_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        quiet;

  int fail_count;
  int pending;
  int frames_closed;
  int frames_ok;

  int n_items = 0;
  int n_requests = 0;
  int n_writes = 0;
  int stall_cycles = 0;
  int phase;

  logic [15:0] cur_timeout;
  logic [15:0] offset_pick;
  logic [7:0]  frame_buf [FRAME_LEN];

  bifp_in_if  req_ch ();
  bifp_out_if rsp_ch ();

  bms_info_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bifp_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .frames_closed (frames_closed),
    .frames_ok     (frames_ok)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result consumer stalls with a chance of 13 in a hundred, except during
  // the quiet phase, where it takes every result at once.
  always @(posedge clk) begin
    rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one request and returns once the parser has taken it. Valid stays
  // high on return, so back-to-back requests follow without a gap. A one-cycle
  // idle gap is inserted first at random, unless the quiet phase is running.
  task automatic send_item(input logic [1:0] m, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= m;
    req_ch.rx_byte <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_items++;
    if (m == MODE_START) n_requests++;
  endtask

  // Each register write ends with the write enable already low, so that it is never
  // lowered and raised in the same time step.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
    if (idx == REG_TIMEOUT) cur_timeout = value;
  endtask

  // Holds the request port idle until every expected result has come back,
  // then lets the parser finish any request that produces nothing. The first
  // wait cycle lets the checker's count catch up with the last request.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A byte that cannot start a frame, for the junk ahead of the magic byte.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == FRAME_MAGIC) ? 8'h00 : b;
  endfunction

  // Builds a reply frame in frame_buf. With a length of 29 or less the
  // checksum is made to match; longer lengths make the summed range run into
  // the checksum bytes themselves, so those frames get random checksum bytes.
  // The extreme flag fills the payload with all-zero and all-one bytes only.
  function automatic void fill_frame(input fault_t fault, input int len, input bit extreme);
    logic [15:0] sum;
    int          p;
    frame_buf[0] = FRAME_MAGIC;
    frame_buf[1] = INFO_TYPE;
    frame_buf[2] = STATUS_OK;
    frame_buf[3] = 8'(len);
    for (p = 4; p < 33; p++) begin
      if (extreme) frame_buf[p] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else frame_buf[p] = 8'($urandom_range(0, 255));
    end
    if (len <= 29) begin
      sum = '0;
      for (p = 4; p < 4 + len; p++) sum = sum + 16'(frame_buf[p]);
      sum = (sum + 16'(len) - 16'd1) ^ CSUM_XOR;
      {frame_buf[33], frame_buf[34]} = sum;
    end else begin
      frame_buf[33] = 8'($urandom_range(0, 255));
      frame_buf[34] = 8'($urandom_range(0, 255));
    end
    case (fault)
      FAULT_TYPE:   frame_buf[1] = INFO_TYPE ^ 8'($urandom_range(1, 255));
      FAULT_STATUS: frame_buf[2] = 8'($urandom_range(1, 255));
      FAULT_CSUM: begin
        p = 33 + $urandom_range(0, 1);
        frame_buf[p] = frame_buf[p] ^ (8'd1 << $urandom_range(0, 7));
      end
      default: ;
    endcase
  endfunction

  // Sends the first count bytes of frame_buf, with a stray tick now and then.
  // With a short timeout such a tick may close the frame early.
  task automatic send_frame(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) send_item(MODE_TICK, noise_byte());
      send_item(MODE_BYTE, frame_buf[i]);
    end
  endtask

  // One well-formed exchange with random content: a start, some junk, and a
  // frame that is mostly whole and clean. A cut frame is closed by enough
  // ticks when the timeout is short, and otherwise left open for the next
  // start to restart.
  task automatic run_request();
    fault_t fault;
    int     pick;
    int     len;
    int     cut;
    send_item(MODE_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3))
      send_item($urandom_range(0, 1) ? MODE_BYTE : MODE_TICK, noise_byte());
    pick  = $urandom_range(0, 99);
    fault = (pick < 70) ? FAULT_NONE : (pick < 80) ? FAULT_TYPE :
            (pick < 90) ? FAULT_STATUS : FAULT_CSUM;
    pick  = $urandom_range(0, 99);
    len   = (pick < 70) ? 29 : (pick < 92) ? $urandom_range(0, 29) : $urandom_range(30, 255);
    fill_frame(fault, len, $urandom_range(0, 9) == 0);
    cut = ($urandom_range(0, 99) < 20) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
    send_frame(cut);
    if (cut < FRAME_LEN && cur_timeout <= 16'd64)
      repeat (int'(cur_timeout) + 1) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
    // Occasionally bytes, ticks and spare-mode requests follow after the frame.
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Pure noise: any mode with any byte, starts kept rare.
  task automatic run_noise();
    logic [1:0] m;
    repeat ($urandom_range(4, 12)) begin
      m = ($urandom_range(0, 99) < 8) ? MODE_START : 2'($urandom_range(1, 3));
      send_item(m, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_TIMEOUT;
    cfg_data       <= '0;
    quiet          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.mode    <= MODE_START;
    req_ch.rx_byte <= '0;
    cur_timeout     = TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset settings first. Nothing is open yet, so a
    // magic byte, a tick and the spare mode must all be dropped.
    send_item(MODE_BYTE, FRAME_MAGIC);
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_SPARE, 8'hFF);
    // Junk ahead of the magic byte, including a spare-mode request carrying
    // the magic value, which must not start the frame; then a clean frame of
    // all-zero and all-one fields.
    send_item(MODE_START, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_SPARE, FRAME_MAGIC);
    fill_frame(FAULT_NONE, 29, 1'b1);
    send_frame(FRAME_LEN);
    // A start while a request is open restarts it without a result.
    send_item(MODE_START, 8'hFF);
    send_item(MODE_BYTE, FRAME_MAGIC);
    send_item(MODE_START, 8'h00);
    fill_frame(FAULT_TYPE, 29, 1'b0);
    send_frame(FRAME_LEN);

    // Zero timeout and zero offset: the first tick closes the frame. With no
    // byte received the magic check fails; with only the three header bytes
    // the zero length makes the zero checksum match.
    settle();
    write_reg(REG_TIMEOUT, 16'h0000);
    write_reg(REG_TEMP_OFFSET, 16'h0000);
    send_item(MODE_START, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_START, 8'h00);
    send_item(MODE_BYTE, FRAME_MAGIC);
    send_item(MODE_BYTE, INFO_TYPE);
    send_item(MODE_BYTE, STATUS_OK);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_TICK, 8'hFF);

    // Largest settings: a length byte that runs the sum past the frame end,
    // and a clean frame whose temperatures wrap with the full offset.
    settle();
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_TEMP_OFFSET, 16'hFFFF);
    send_item(MODE_START, 8'h00);
    fill_frame(FAULT_NONE, 255, 1'b0);
    send_frame(FRAME_LEN);
    send_item(MODE_START, 8'h00);
    fill_frame(FAULT_NONE, 29, 1'b1);
    send_frame(FRAME_LEN);

    // Random part: each phase drains the parser, picks new register values
    // and runs a handful of exchanges. The third phase runs without gaps on
    // either side.
    phase = 0;
    while (n_items < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: write_reg(REG_TIMEOUT, 16'($urandom_range(0, 40)));
        5:             write_reg(REG_TIMEOUT, 16'h0000);
        6:             write_reg(REG_TIMEOUT, 16'hFFFF);
        7:             write_reg(REG_TIMEOUT, TIMEOUT_RESET);
        default:       write_reg(REG_TIMEOUT, 16'($urandom_range(41, 65535)));
      endcase
      case ($urandom_range(0, 7))
        0, 1:    offset_pick = 16'h0000;
        2:       offset_pick = 16'hFFFF;
        3:       offset_pick = TEMP_OFFSET_RESET;
        default: offset_pick = 16'($urandom_range(0, 65535));
      endcase
      write_reg(REG_TEMP_OFFSET, offset_pick);
      quiet <= (phase == 2);
      repeat ($urandom_range(3, 7)) begin
        if ($urandom_range(0, 9) == 0) run_noise();
        else run_request();
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d starts) over %0d phases with %0d register writes.",
             n_items, n_requests, phase, n_writes);
    $display("Checked %0d closed frames, %0d of them decoded without error.",
             frames_closed, frames_ok);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
